// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock and switched off during reset.
`define BACD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define BACD_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bacd_pkg.sv -----
// Shared types and constants of the block average change detector.
package bacd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_BLOCK_DEFAULT = 128;

  localparam int OP_W = 2;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;
  localparam int M_FIELDS_W = 4 * SAMPLE_BITS + 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int BLOCK_LEN_W = 8;
  localparam int THRESHOLD_W = 12;
  localparam int PRIME_W = 8;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = '1;
  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 8'd10;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 12'd500;
  localparam logic [PRIME_W-1:0] PRIME_RESET = 8'd5;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_REARM  = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_LEN = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_PRIME     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DETECT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/block_average_change_detector.sv -----
// Top level of the block average change detector.
//
//  Channel  Direction  Handshake             Payload
//  s        in         s_tvalid / s_tready   s_tdata: sample; s_tuser: op
//  m        out        m_tvalid / m_tready   m_tdata: averages, min, max, flags
//  cfg      in         cfg_we                cfg_index, cfg_data
//
// A tick, re-arm or sample that does not end a block goes straight to the detect state.
// A sample that ends a block first passes through the divide state, where the bit-serial
// divider produces one quotient bit per cycle, and then reaches the detect state.
// Reset is synchronous and active high; afterwards the block accepts an item at once.
// A new item is taken while the previous result waits in the output register; a stalled
// output holds the finished result in the detect state until the register frees up.
module block_average_change_detector #(
  parameter int MAX_BLOCK = bacd_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0: sample[11:0], zero padding
  input  logic [bacd_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser from bit 0: op[1:0]
  input  logic [bacd_pkg::OP_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata from bit 0: average, prev_average, block_min, block_max (12 bits each),
  // block_done, detect_pulse, detect_latched, primed, zero padding
  output logic [bacd_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [bacd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bacd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SB = bacd_pkg::SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = SB + $clog2(MAX_BLOCK);

  bacd_pkg::state_t state;
  bacd_pkg::state_t state_next;
  bacd_pkg::op_t    op;

  logic [bacd_pkg::BLOCK_LEN_W-1:0] block_len;
  logic [bacd_pkg::THRESHOLD_W-1:0] change_threshold;
  logic [bacd_pkg::PRIME_W-1:0]     prime_seconds;
  logic [bacd_pkg::PRIME_W-1:0]     prime_countdown;
  logic                             output_latch;
  logic                             block_done;
  logic [SB-1:0]                    current_average;
  logic [SB-1:0]                    reference_average;
  logic [SB-1:0]                    published_min;
  logic [SB-1:0]                    published_max;

  logic [SB-1:0] out_average;
  logic [SB-1:0] out_prev;
  logic [SB-1:0] out_min;
  logic [SB-1:0] out_max;
  logic          out_done;
  logic          out_pulse;
  logic          out_latched;
  logic          out_primed;

  logic                  accept;
  logic                  sample_en;
  logic                  div_start;
  logic                  commit;
  logic                  out_free;
  logic [CNT_W-1:0]      len;
  logic                  acc_complete;
  logic [SUM_W-1:0]      acc_sum;
  logic [SB-1:0]         acc_min;
  logic [SB-1:0]         acc_max;
  bacd_pkg::div_status_t div_status;
  logic [SUM_W-1:0]      quotient;
  logic [SB-1:0]         diff;
  logic                  primed;
  logic                  hit;

  assign op        = bacd_pkg::op_t'(s_tuser);
  assign s_tready  = (state == bacd_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign sample_en = accept && (op == bacd_pkg::OP_SAMPLE);
  assign div_start = sample_en && acc_complete;
  assign out_free  = !m_tvalid || m_tready;

  // A zero length counts as one; a length beyond the block capacity saturates.
  always_comb begin
    if (block_len == '0) begin
      len = CNT_W'(1);
    end else if (32'(block_len) > MAX_BLOCK) begin
      len = CNT_W'(MAX_BLOCK);
    end else begin
      len = CNT_W'(block_len);
    end
  end

  bacd_accum #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .sample_en (sample_en),
    .sample    (s_tdata[SB-1:0]),
    .len       (len),
    .complete  (acc_complete),
    .total     (acc_sum),
    .blk_min   (acc_min),
    .blk_max   (acc_max)
  );

  bacd_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (len),
    .status   (div_status),
    .quotient (quotient)
  );

  // The detection check runs on the state that the item's op has already updated.
  assign diff   = (reference_average > current_average) ?
                  (reference_average - current_average) :
                  (current_average - reference_average);
  assign primed = (prime_countdown == '0);
  assign hit    = primed && (diff > change_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bacd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    commit     = 1'b0;
    unique case (state)
      bacd_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = div_start ? bacd_pkg::ST_DIVIDE : bacd_pkg::ST_DETECT;
        end
      end
      bacd_pkg::ST_DIVIDE: begin
        if (div_status.done) begin
          state_next = bacd_pkg::ST_DETECT;
        end
      end
      bacd_pkg::ST_DETECT: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = bacd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bacd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len         <= bacd_pkg::BLOCK_LEN_RESET;
      change_threshold  <= bacd_pkg::THRESHOLD_RESET;
      prime_seconds     <= bacd_pkg::PRIME_RESET;
      prime_countdown   <= bacd_pkg::PRIME_RESET;
      output_latch      <= 1'b0;
      block_done        <= 1'b0;
      current_average   <= '0;
      reference_average <= '0;
      published_min     <= bacd_pkg::SAMPLE_MASK;
      published_max     <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bacd_pkg::REG_BLOCK_LEN: block_len <= cfg_data[bacd_pkg::BLOCK_LEN_W-1:0];
          bacd_pkg::REG_THRESHOLD: change_threshold <= cfg_data[bacd_pkg::THRESHOLD_W-1:0];
          bacd_pkg::REG_PRIME:     prime_seconds <= cfg_data[bacd_pkg::PRIME_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        block_done <= div_start;
        unique case (op)
          bacd_pkg::OP_TICK: begin
            if (!primed) begin
              prime_countdown <= prime_countdown - bacd_pkg::PRIME_W'(1);
            end
          end
          bacd_pkg::OP_REARM: begin
            prime_countdown <= prime_seconds;
            output_latch    <= 1'b0;
          end
          default: ;
        endcase
        if (div_start) begin
          reference_average <= current_average;
          published_min     <= acc_min;
          published_max     <= acc_max;
        end
      end

      if (div_status.done) begin
        current_average <= quotient[SB-1:0];
      end

      if (commit) begin
        m_tvalid <= 1'b1;
        if (hit) begin
          output_latch      <= 1'b1;
          reference_average <= current_average;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_average <= current_average;
      out_prev    <= hit ? current_average : reference_average;
      out_min     <= published_min;
      out_max     <= published_max;
      out_done    <= block_done;
      out_pulse   <= hit;
      out_latched <= hit || output_latch;
      out_primed  <= primed;
    end
  end

  assign m_tdata = {(bacd_pkg::M_TDATA_W - bacd_pkg::M_FIELDS_W)'(0),
                    out_primed, out_latched, out_pulse, out_done,
                    out_max, out_min, out_prev, out_average};

endmodule

// ----- rtl/bacd_accum.sv -----
// Running count, sum, minimum and maximum of the block being collected.
module bacd_accum #(
  parameter int CNT_W = 8,
  parameter int SUM_W = 19
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_en,
  input  logic [bacd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [CNT_W-1:0]                 len,
  output logic                             complete,
  output logic [SUM_W-1:0]                 total,
  output logic [bacd_pkg::SAMPLE_BITS-1:0] blk_min,
  output logic [bacd_pkg::SAMPLE_BITS-1:0] blk_max
);

  logic [CNT_W-1:0]                 count;
  logic [SUM_W-1:0]                 sum;
  logic [bacd_pkg::SAMPLE_BITS-1:0] run_min;
  logic [bacd_pkg::SAMPLE_BITS-1:0] run_max;
  logic [CNT_W-1:0]                 count_inc;

  // The count stays below the largest length in use, so the increment cannot wrap.
  assign count_inc = count + CNT_W'(1);
  assign total     = sum + SUM_W'(sample);
  assign blk_min   = (sample < run_min) ? sample : run_min;
  assign blk_max   = (sample > run_max) ? sample : run_max;
  // A length lowered mid-block ends the block at once.
  assign complete  = (count_inc >= len);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      run_min <= bacd_pkg::SAMPLE_MASK;
      run_max <= '0;
    end else if (sample_en) begin
      if (complete) begin
        count   <= '0;
        sum     <= '0;
        run_min <= bacd_pkg::SAMPLE_MASK;
        run_max <= '0;
      end else begin
        count   <= count_inc;
        sum     <= total;
        run_min <= blk_min;
        run_max <= blk_max;
      end
    end
  end

endmodule

// ----- rtl/bacd_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module bacd_divider #(
  parameter int DIVIDEND_W = 19,
  parameter int DIVISOR_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIVIDEND_W-1:0]      dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output bacd_pkg::div_status_t      status,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  // The dividend leaves the top of the shift register while quotient bits enter the bottom.
  assign rem_shift = {rem, dq[DIVIDEND_W-1]};
  assign fits      = (rem_shift >= {1'b0, dvs});
  assign rem_sub   = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIVIDEND_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[DIVIDEND_W-2:0], fits};
      rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = dq;

endmodule

// ----- rtl/bacd_checker.sv -----
// Port-level checker of the block average change detector, bound to the top level.
`include "assert_macros.svh"

module bacd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bacd_pkg::M_TDATA_W-1:0] m_tdata
);

  // A stalled result keeps its value until the transfer.
  `BACD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

  // Each accepted item keeps the input closed while it is worked on.
  `BACD_ASSERT(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready, "input open while an item is in work")

  // A detection is only reported while primed, sets the latch and moves the reference.
  `BACD_ASSERT(a_detect, clk, rst, m_tvalid && m_tdata[49] |-> m_tdata[50] && m_tdata[51] && (m_tdata[23:12] == m_tdata[11:0]), "detection result inconsistent")

  // Reset leaves no result pending and the input open.
  `BACD_ASSERT_NR(a_reset, clk, rst |=> !m_tvalid && s_tready, "state after reset wrong")

endmodule

bind block_average_change_detector bacd_checker u_checker (.*);
